// ===== rtl/gbns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbns_pkg
// Shared widths, codes and types of the go-back-n sender window block.
// ----------------------------------------------------------------------------
package gbns_pkg;

    localparam int WINDOW_SLOTS_DEF = 8;
    localparam int MAX_RESULTS      = 8;
    localparam int CNT_W            = $clog2(MAX_RESULTS);

    localparam int MODE_W     = 2;
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;

    localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETX = 2'd2;

    localparam logic [STATUS_W-1:0] ST_TRANSMIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RETRANSMIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EOD        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ACK_OK     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ACK_IGN    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic take;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic walk_needed;
        logic hit;
        logic walk_last;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SEQ_W-1:0]      seq_number;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [LEN_W-1:0]      packet_length;
        logic [SEQ_W-1:0]      header_ack;
        logic                  restart_timer;
        logic                  newly_acked;
        logic                  last;
    } t_result;

endpackage

// ===== rtl/gbns_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbns_ifs
// Request and result channels of the go-back-n sender window block.
// ----------------------------------------------------------------------------
interface gbns_in_if;
    import gbns_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  ack_number;
    logic [LEN_W-1:0]  chunk_length;
    logic [SEQ_W-1:0]  peer_ack;

    modport source (output valid, mode, ack_number, chunk_length, peer_ack, input ready);
    modport sink   (input valid, mode, ack_number, chunk_length, peer_ack, output ready);
endinterface

interface gbns_out_if;
    import gbns_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SEQ_W-1:0]      seq_number;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [LEN_W-1:0]      packet_length;
    logic [SEQ_W-1:0]      header_ack;
    logic                  restart_timer;
    logic                  newly_acked;
    logic                  last;

    modport source (output valid, status, seq_number, slot_index, packet_length, header_ack,
                    restart_timer, newly_acked, last, input ready);
    modport sink   (input valid, status, seq_number, slot_index, packet_length, header_ack,
                    restart_timer, newly_acked, last, output ready);
endinterface

// ===== rtl/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-n sender window bookkeeping: transmit, cumulative ack, retransmit.
// ----------------------------------------------------------------------------
// Send, ack and unused-mode requests are answered by one result each and are
// taken one per cycle while the result register drains; the result register
// decouples the two channels. A timeout request walks the window slot by slot
// from the oldest pending packet: an empty slot is passed over, a valid one
// takes a slot memory read, then a result load, and at most eight packets are
// resent. No request is taken during the walk. Slot memory needs no clearing.
module go_back_n_sender_window #(
    parameter int WINDOW_SLOTS = gbns_pkg::WINDOW_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbns_in_if.sink     i_req,
    gbns_out_if.source  o_res
);
    import gbns_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result result;
    logic    walking;
    logic    out_valid;

    gbns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .o_walking  (walking)
    );

    gbns_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_req.mode),
        .i_ack_number   (i_req.ack_number),
        .i_chunk_length (i_req.chunk_length),
        .i_peer_ack     (i_req.peer_ack),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (out_valid),
        .o_result       (result)
    );

    assign o_res.valid         = out_valid;
    assign o_res.status        = result.status;
    assign o_res.seq_number    = result.seq_number;
    assign o_res.slot_index    = result.slot_index;
    assign o_res.packet_length = result.packet_length;
    assign o_res.header_ack    = result.header_ack;
    assign o_res.restart_timer = result.restart_timer;
    assign o_res.newly_acked   = result.newly_acked;
    assign o_res.last          = result.last;

    // no request taken while the retransmit walk runs
    a_no_req_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walking |-> !i_req.ready)
        else $error("request accepted during retransmit walk");

    a_emit_loads_retx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> (o_res.valid && o_res.status == ST_RETRANSMIT))
        else $error("walk step did not present a retransmit result");

    // a non-final result only comes out of an unfinished walk
    a_partial_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |-> walking)
        else $error("non-final result outside retransmit walk");

endmodule

// ===== rtl/gbns_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbns_ctrl
// Sequencer: takes requests and steps the retransmit walk over the window.
// ----------------------------------------------------------------------------
module gbns_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  gbns_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output gbns_pkg::t_cmd  o_cmd,
    output logic           o_walking
);
    import gbns_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.out_busy && i_stat.walk_needed) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.hit) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_stat.out_busy) begin
                    n_state = i_stat.walk_last ? S_IDLE : S_WALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                o_cmd.take = i_in_valid && !i_stat.out_busy;
            end
            S_WALK: begin
                o_cmd.scan = 1'b1;
            end
            S_LOAD: begin
                o_cmd.emit = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_walking = (r_state != S_IDLE);

endmodule

// ===== rtl/gbns_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbns_dp
// Window datapath: sequence counters, slot valid bits, slot memory, walk
// registers and the result register.
// ----------------------------------------------------------------------------
module gbns_dp #(
    parameter int WINDOW_SLOTS = gbns_pkg::WINDOW_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbns_pkg::t_cmd                i_cmd,
    output gbns_pkg::t_stat               o_stat,
    input  logic [gbns_pkg::MODE_W-1:0]   i_mode,
    input  logic [gbns_pkg::SEQ_W-1:0]    i_ack_number,
    input  logic [gbns_pkg::LEN_W-1:0]    i_chunk_length,
    input  logic [gbns_pkg::SEQ_W-1:0]    i_peer_ack,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output gbns_pkg::t_result             o_result
);
    import gbns_pkg::*;

    localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW_SLOTS - 1);
    localparam logic [SEQ_W-1:0] WIN_SEQ   = SEQ_W'(WINDOW_SLOTS);
    localparam logic [CW:0]      WIN_EXT   = (CW + 1)'(WINDOW_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

    logic [SEQ_W-1:0]        r_base_seq;
    logic [SEQ_W-1:0]        r_next_seq;
    logic [SW-1:0]           r_base_slot;
    logic [SW-1:0]           r_next_slot;
    logic [WINDOW_SLOTS-1:0] r_valid;
    logic [WINDOW_SLOTS-1:0] n_valid;

    logic [LEN_W-1:0]        r_mem_len  [WINDOW_SLOTS];
    logic [SEQ_W-1:0]        r_mem_pack [WINDOW_SLOTS];
    logic [LEN_W-1:0]        r_rd_len;
    logic [SEQ_W-1:0]        r_rd_pack;

    logic [SW-1:0]           r_walk_slot;
    logic [SEQ_W-1:0]        r_walk_seq;
    logic [WINDOW_SLOTS-1:0] r_walk_mask;
    logic [CNT_W-1:0]        r_emit_cnt;

    logic                    r_out_valid;
    t_result                 r_result;

    logic [SEQ_W-1:0]        outstanding;
    logic                    win_full;
    logic [SEQ_W-1:0]        ack_dist;
    logic                    ack_ok;
    logic [CW-1:0]           dist_c;
    logic [WINDOW_SLOTS-1:0] clr;
    logic                    newly;
    logic [CW:0]             base_sum;
    logic [SW-1:0]           ack_base_slot;
    logic [SW-1:0]           next_slot_inc;
    logic [SW-1:0]           walk_slot_inc;
    logic [WINDOW_SLOTS-1:0] rest;
    logic                    hit;
    logic                    walk_last;
    logic                    walk_needed;
    logic                    do_write;
    logic                    do_ack;
    logic                    load_imm;
    logic                    advance;
    t_result                 imm_res;
    t_result                 walk_res;

    assign outstanding = r_next_seq - r_base_seq;
    assign win_full    = (outstanding >= WIN_SEQ);
    assign ack_dist    = i_ack_number - r_base_seq;
    assign ack_ok      = (ack_dist != '0) && (ack_dist <= outstanding);
    // an accepted ack lies at most one window ahead of base
    assign dist_c      = ack_dist[CW-1:0];

    // slots whose distance from base falls below the ack distance
    always_comb begin
        logic [CW:0] base_ext;
        logic [CW:0] off;
        base_ext = (CW + 1)'(r_base_slot);
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            if ((CW + 1)'(i) >= base_ext) begin
                off = (CW + 1)'(i) - base_ext;
            end else begin
                off = (CW + 1)'(i) + WIN_EXT - base_ext;
            end
            clr[i] = (off < {1'b0, dist_c});
        end
    end

    assign newly         = |(r_valid & clr);
    assign base_sum      = (CW + 1)'(r_base_slot) + {1'b0, dist_c};
    assign ack_base_slot = (base_sum >= WIN_EXT) ? SW'(base_sum - WIN_EXT) : SW'(base_sum);
    assign next_slot_inc = (r_next_slot == LAST_SLOT) ? '0 : r_next_slot + 1'b1;
    assign walk_slot_inc = (r_walk_slot == LAST_SLOT) ? '0 : r_walk_slot + 1'b1;

    always_comb begin
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            rest[i] = r_walk_mask[i] && (SW'(i) != r_walk_slot);
        end
    end

    assign hit         = r_walk_mask[r_walk_slot];
    assign walk_last   = (r_emit_cnt == CNT_LAST) || !(|rest);
    assign walk_needed = (i_mode == MODE_RETX) && (outstanding != '0) && (|r_valid);

    assign do_write = i_cmd.take && (i_mode == MODE_SEND) && !win_full
                      && (i_chunk_length != '0);
    assign do_ack   = i_cmd.take && (i_mode == MODE_ACK) && ack_ok;
    assign load_imm = i_cmd.take && !walk_needed;
    assign advance  = (i_cmd.scan && !hit) || i_cmd.emit;

    always_comb begin
        imm_res      = '0;
        imm_res.last = 1'b1;
        case (i_mode)
            MODE_SEND: begin
                if (win_full) begin
                    imm_res.status = ST_FULL;
                end else if (i_chunk_length == '0) begin
                    imm_res.status = ST_EOD;
                end else begin
                    imm_res.status        = ST_TRANSMIT;
                    imm_res.seq_number    = r_next_seq;
                    imm_res.slot_index    = SLOT_OUT_W'(r_next_slot);
                    imm_res.packet_length = i_chunk_length;
                    imm_res.header_ack    = i_peer_ack;
                    imm_res.restart_timer = (outstanding == '0);
                end
            end
            MODE_ACK: begin
                if (ack_ok) begin
                    imm_res.status      = ST_ACK_OK;
                    imm_res.seq_number  = i_ack_number;
                    imm_res.newly_acked = newly;
                end else begin
                    imm_res.status = ST_ACK_IGN;
                end
            end
            MODE_RETX: begin
                // pending packets but no valid slot still restarts the timer
                imm_res.status        = ST_NOTHING;
                imm_res.restart_timer = (outstanding != '0);
            end
            default: begin
                imm_res.status = ST_NOTHING;
            end
        endcase
    end

    always_comb begin
        walk_res               = '0;
        walk_res.status        = ST_RETRANSMIT;
        walk_res.seq_number    = r_walk_seq;
        walk_res.slot_index    = SLOT_OUT_W'(r_walk_slot);
        walk_res.packet_length = r_rd_len;
        walk_res.header_ack    = r_rd_pack;
        walk_res.restart_timer = walk_last;
        walk_res.last          = walk_last;
    end

    always_comb begin
        n_valid = r_valid;
        if (do_write) begin
            n_valid[r_next_slot] = 1'b1;
        end
        if (do_ack) begin
            n_valid = r_valid & ~clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seq  <= '0;
            r_next_seq  <= '0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_valid     <= '0;
            r_walk_slot <= '0;
            r_walk_seq  <= '0;
            r_walk_mask <= '0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (do_write) begin
                r_next_seq  <= r_next_seq + 1'b1;
                r_next_slot <= next_slot_inc;
            end
            if (do_ack) begin
                r_base_seq  <= i_ack_number;
                r_base_slot <= ack_base_slot;
            end
            if (i_cmd.take && walk_needed) begin
                r_walk_slot <= r_base_slot;
                r_walk_seq  <= r_base_seq;
                r_walk_mask <= r_valid;
                r_emit_cnt  <= '0;
            end else if (advance) begin
                r_walk_slot <= walk_slot_inc;
                r_walk_seq  <= r_walk_seq + 1'b1;
            end
            if (i_cmd.emit) begin
                r_walk_mask <= rest;
                r_emit_cnt  <= r_emit_cnt + 1'b1;
            end
            if (load_imm || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_imm) begin
            r_result <= imm_res;
        end else if (i_cmd.emit) begin
            r_result <= walk_res;
        end
    end

    // slot memory: written on transmit, read once per walk step
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem_len[r_next_slot]  <= i_chunk_length;
            r_mem_pack[r_next_slot] <= i_peer_ack;
        end
        if (i_cmd.scan) begin
            r_rd_len  <= r_mem_len[r_walk_slot];
            r_rd_pack <= r_mem_pack[r_walk_slot];
        end
    end

    assign o_stat.walk_needed = walk_needed;
    assign o_stat.hit         = hit;
    assign o_stat.walk_last   = walk_last;
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_result;

endmodule

// ===== bench/tb_go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window
// Self-checking bench for the go-back-n sender window block.
// ----------------------------------------------------------------------------
// A directed opening exercises the empty, full and end-of-data answers, acks
// in and out of the window, a full-window retransmit and the unused mode. It
// is followed by mostly well-formed random send/ack/timeout traffic with some
// noise. A window predictor runs on every accepted request. Each result is
// compared field by field with the oldest predicted one. Both channels stall
// at random, and once the result side holds off long enough to back up input.
module tb_go_back_n_sender_window;
    import gbns_pkg::*;

    localparam int SLOTS           = WINDOW_SLOTS_DEF;
    localparam int RANDOM_REQUESTS = 210;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int LONG_HOLD       = 150;
    localparam int MAX_REPORTS     = 40;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  ack_number;
        logic [LEN_W-1:0]  chunk_length;
        logic [SEQ_W-1:0]  peer_ack;
    } t_request;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gbns_in_if  req_if ();
    gbns_out_if res_if ();

    go_back_n_sender_window dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // driven registers, known from time zero
    logic     tx_valid = 1'b0;
    t_request tx_item  = '0;
    logic     rx_ready = 1'b0;

    assign req_if.valid        = tx_valid;
    assign req_if.mode         = tx_item.mode;
    assign req_if.ack_number   = tx_item.ack_number;
    assign req_if.chunk_length = tx_item.chunk_length;
    assign req_if.peer_ack     = tx_item.peer_ack;
    assign res_if.ready        = rx_ready;

    t_request pending_requests[$];
    t_result  expected_results[$];

    // predicted window state, as left by reset
    logic [SEQ_W-1:0] window_base = '0;
    logic [SEQ_W-1:0] window_next = '0;
    logic             slot_held    [SLOTS] = '{default: 1'b0};
    logic [LEN_W-1:0] slot_len     [SLOTS];
    logic [SEQ_W-1:0] slot_hdr_ack [SLOTS];

    // request generator's own view of base and next
    logic [SEQ_W-1:0] gen_base = '0;
    logic [SEQ_W-1:0] gen_next = '0;

    int mismatches       = 0;
    int requests_offered = 0;
    int requests_taken   = 0;
    int results_checked  = 0;
    int results_taken    = 0;
    int transmits        = 0;
    int retransmits      = 0;
    int acks_accepted    = 0;
    int full_answers     = 0;
    int cycles           = 0;
    int tx_gap           = 0;
    int rx_hold          = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // window predictor
    // ------------------------------------------------------------------
    task automatic predict_request(input t_request rq);
        logic [SEQ_W-1:0] outstanding;
        logic [SEQ_W-1:0] ack_dist;
        logic [SEQ_W-1:0] seq;
        int unsigned      span;
        int unsigned      s;
        logic             cleared;
        t_result          r;
        t_result          resends[$];

        outstanding = window_next - window_base;
        r = '0;
        r.last = 1'b1;
        case (rq.mode)
            MODE_SEND: begin
                if (outstanding >= SLOTS) begin
                    r.status = ST_FULL;
                end else if (rq.chunk_length == '0) begin
                    r.status = ST_EOD;
                end else begin
                    s = window_next % SLOTS;
                    slot_len[s]      = rq.chunk_length;
                    slot_hdr_ack[s]  = rq.peer_ack;
                    slot_held[s]     = 1'b1;
                    r.status         = ST_TRANSMIT;
                    r.seq_number     = window_next;
                    r.slot_index     = SLOT_OUT_W'(s);
                    r.packet_length  = rq.chunk_length;
                    r.header_ack     = rq.peer_ack;
                    r.restart_timer  = (outstanding == '0);
                    window_next      = window_next + 1;
                end
                expected_results.push_back(r);
            end
            MODE_ACK: begin
                ack_dist = rq.ack_number - window_base;
                if (ack_dist == '0 || ack_dist > outstanding) begin
                    r.status = ST_ACK_IGN;
                end else begin
                    span = (ack_dist > SLOTS) ? SLOTS : ack_dist;
                    cleared = 1'b0;
                    for (int d = 0; d < span; d++) begin
                        s = (window_base + d) % SLOTS;
                        if (slot_held[s]) begin
                            slot_held[s] = 1'b0;
                            cleared = 1'b1;
                        end
                    end
                    window_base   = rq.ack_number;
                    r.status      = ST_ACK_OK;
                    r.seq_number  = rq.ack_number;
                    r.newly_acked = cleared;
                end
                expected_results.push_back(r);
            end
            MODE_RETX: begin
                if (outstanding == '0) begin
                    r.status = ST_NOTHING;
                    expected_results.push_back(r);
                end else begin
                    span = (outstanding > SLOTS) ? SLOTS : outstanding;
                    for (int d = 0; d < span && resends.size() < MAX_RESULTS; d++) begin
                        seq = window_base + d;
                        s = seq % SLOTS;
                        if (slot_held[s]) begin
                            r = '0;
                            r.status        = ST_RETRANSMIT;
                            r.seq_number    = seq;
                            r.slot_index    = SLOT_OUT_W'(s);
                            r.packet_length = slot_len[s];
                            r.header_ack    = slot_hdr_ack[s];
                            resends.push_back(r);
                        end
                    end
                    if (resends.size() == 0) begin
                        // pending packets but no valid slot left
                        r = '0;
                        r.status        = ST_NOTHING;
                        r.restart_timer = 1'b1;
                        r.last          = 1'b1;
                        expected_results.push_back(r);
                    end else begin
                        r = resends.pop_back();
                        r.restart_timer = 1'b1;
                        r.last          = 1'b1;
                        resends.push_back(r);
                        foreach (resends[i]) expected_results.push_back(resends[i]);
                    end
                end
            end
            default: begin
                r.status = ST_NOTHING;
                expected_results.push_back(r);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------
    // the length comes in as a full word and is cut to the field here
    task automatic queue_request(input logic [MODE_W-1:0] m, input logic [SEQ_W-1:0] a,
                                 input logic [SEQ_W-1:0] c, input logic [SEQ_W-1:0] p);
        t_request         rq;
        logic [SEQ_W-1:0] outst;
        logic [SEQ_W-1:0] ack_dist;
        logic [LEN_W-1:0] clen;

        clen     = LEN_W'(c);
        outst    = gen_next - gen_base;
        ack_dist = a - gen_base;
        if (m == MODE_SEND && outst < SLOTS && clen != '0)
            gen_next = gen_next + 1;
        if (m == MODE_ACK && ack_dist != '0 && ack_dist <= outst)
            gen_base = a;
        rq.mode         = m;
        rq.ack_number   = a;
        rq.chunk_length = clen;
        rq.peer_ack     = p;
        pending_requests.push_back(rq);
    endtask

    initial begin
        int               pick;
        logic [SEQ_W-1:0] outst;
        logic [SEQ_W-1:0] clen;

        // empty window corners
        queue_request(MODE_RETX, $urandom, $urandom, $urandom);
        queue_request(MODE_ACK, '0, $urandom, $urandom);
        queue_request(MODE_UNUSED, $urandom, $urandom, $urandom);
        queue_request(MODE_SEND, $urandom, '0, $urandom);
        // fill the window, extremes of length and header ack first
        queue_request(MODE_SEND, '0, '1, '1);
        queue_request(MODE_SEND, '1, SEQ_W'(1), '0);
        for (int i = 0; i < SLOTS - 2; i++)
            queue_request(MODE_SEND, $urandom, $urandom_range(1, 65535), $urandom);
        // full window answers even with a zero length
        queue_request(MODE_SEND, $urandom, '0, $urandom);
        queue_request(MODE_SEND, $urandom, '1, $urandom);
        queue_request(MODE_RETX, $urandom, $urandom, $urandom);
        // acks outside the window
        queue_request(MODE_ACK, gen_base, $urandom, $urandom);
        queue_request(MODE_ACK, gen_next + 1, $urandom, $urandom);
        queue_request(MODE_ACK, '1, $urandom, $urandom);
        // partial then complete ack
        queue_request(MODE_ACK, gen_base + 3, $urandom, $urandom);
        queue_request(MODE_RETX, $urandom, $urandom, $urandom);
        queue_request(MODE_ACK, gen_next, $urandom, $urandom);
        queue_request(MODE_RETX, $urandom, $urandom, $urandom);
        queue_request(MODE_SEND, $urandom, $urandom_range(1, 65535), $urandom);
        queue_request(MODE_ACK, gen_next, $urandom, $urandom);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            pick  = $urandom_range(0, 99);
            outst = gen_next - gen_base;
            clen  = ($urandom_range(0, 19) == 0) ? '0 : SEQ_W'($urandom_range(1, 65535));
            if (pick < 48) begin
                queue_request(MODE_SEND, $urandom, clen, $urandom);
            end else if (pick < 72 && outst != '0) begin
                queue_request(MODE_ACK, gen_base + $urandom_range(1, outst), $urandom, $urandom);
            end else if (pick < 84) begin
                queue_request(MODE_RETX, $urandom, $urandom, $urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: queue_request(MODE_ACK, $urandom, $urandom, $urandom);
                    1: queue_request(MODE_ACK, gen_base, $urandom, $urandom);
                    2: queue_request(MODE_ACK, gen_next + 1, $urandom, $urandom);
                    default: queue_request(MODE_UNUSED, $urandom, $urandom, $urandom);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // reset and request driver
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
            tx_gap = 0;
        end else if (!tx_valid || req_if.ready) begin
            if (tx_gap > 0) begin
                tx_valid <= 1'b0;
                tx_gap = tx_gap - 1;
            end else if (pending_requests.size() != 0) begin
                tx_item  <= pending_requests.pop_front();
                tx_valid <= 1'b1;
                requests_offered++;
                // every third stretch of 40 requests goes back to back
                tx_gap = ((requests_offered / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
            end else begin
                tx_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_hold = 0;
        end else if (res_if.valid && rx_ready) begin
            results_taken++;
            if (results_taken == 60)
                rx_hold = LONG_HOLD;
            else if ((results_taken / 50) % 3 == 2)
                rx_hold = 0;
            else
                rx_hold = $urandom_range(0, 18);
            rx_ready <= (rx_hold == 0);
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            rx_ready <= (rx_hold == 0);
        end else begin
            rx_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // predictor hookup and result check
    // ------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [SEQ_W-1:0] want,
                                        input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_request seen;
        t_result  got;
        t_result  want;

        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                seen.mode         = req_if.mode;
                seen.ack_number   = req_if.ack_number;
                seen.chunk_length = req_if.chunk_length;
                seen.peer_ack     = req_if.peer_ack;
                predict_request(seen);
                requests_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                got.status        = res_if.status;
                got.seq_number    = res_if.seq_number;
                got.slot_index    = res_if.slot_index;
                got.packet_length = res_if.packet_length;
                got.header_ack    = res_if.header_ack;
                got.restart_timer = res_if.restart_timer;
                got.newly_acked   = res_if.newly_acked;
                got.last          = res_if.last;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got status %0d seq 0x%0h",
                                 $time, got.status, got.seq_number);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("seq_number", want.seq_number, got.seq_number);
                    check_field("slot_index", want.slot_index, got.slot_index);
                    check_field("packet_length", want.packet_length, got.packet_length);
                    check_field("header_ack", want.header_ack, got.header_ack);
                    check_field("restart_timer", want.restart_timer, got.restart_timer);
                    check_field("newly_acked", want.newly_acked, got.newly_acked);
                    check_field("last", want.last, got.last);
                end
                results_checked++;
                case (got.status)
                    ST_TRANSMIT:   transmits++;
                    ST_RETRANSMIT: retransmits++;
                    ST_ACK_OK:     acks_accepted++;
                    ST_FULL:       full_answers++;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_requests.size() != 0 || tx_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("requests taken %0d, results checked %0d, mismatches %0d",
                 requests_taken, results_checked, mismatches);
        $display("transmits %0d, retransmits %0d, acks accepted %0d, full-window answers %0d",
                 transmits, retransmits, acks_accepted, full_answers);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
